@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// gdfs_pkg
// Types, constants and tables shared by the grid path search block.
// ----------------------------------------------------------------------------
package gdfs_pkg;

  localparam int GRID_WIDTH = 6;
  localparam int TILE_COUNT = 36;
  localparam int TILE_W     = 6;
  localparam int CUR_W      = 3;
  localparam int COL_W      = $clog2(GRID_WIDTH);
  localparam int TILE_SPAN  = 1 << TILE_W;
  localparam int DEPTH_W    = $clog2(TILE_COUNT + 1);
  localparam int ADDR_W     = $clog2(TILE_COUNT);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Cursor value once all four directions have been tried.
  localparam logic [CUR_W-1:0] NB_DONE = 3'd4;

  localparam int FLAG_UNOCC = 0;
  localparam int FLAG_FLAT  = 1;

  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    OUT_SAME = 2'd0,
    OUT_NONE = 2'd1,
    OUT_PATH = 2'd2
  } out_sel_t;

  typedef struct packed {
    logic              op;
    logic [TILE_W-1:0] tile_index;
    logic              tile_unoccupied;
    logic              tile_flat;
    logic [TILE_W-1:0] start_tile;
    logic [TILE_W-1:0] goal_tile;
  } in_item_t;

  typedef struct packed {
    logic [TILE_W-1:0] path_tile;
    logic              found;
    logic              last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     flag_wr;
    logic     capture;
    logic     init;
    logic     try_nb;
    logic     push;
    logic     pop;
    logic     pop_load;
    logic     store_top;
    logic     emit_next;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_search;
    logic start_eq_goal;
    logic start_oob;
    logic cur_done;
    logic enter;
    logic nb_is_goal;
    logic depth_is_one;
    logic k_is_last;
    logic out_free;
  } dp_status_t;

  // Column of every tile code, worked out at elaboration.
  typedef logic [COL_W-1:0] col_tab_t [TILE_SPAN];

  function automatic col_tab_t build_col_tab();
    col_tab_t tab;
    for (int i = 0; i < TILE_SPAN; i++) begin
      tab[i] = COL_W'(i % GRID_WIDTH);
    end
    return tab;
  endfunction

  localparam col_tab_t COL_TAB = build_col_tab();

endpackage

@@ hw/rtl/gdfs_ifs.sv @@
// ----------------------------------------------------------------------------
// gdfs_in_if / gdfs_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface gdfs_in_if;
  import gdfs_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gdfs_out_if;
  import gdfs_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/gdfs_datapath.sv @@
// ----------------------------------------------------------------------------
// gdfs_datapath
// Tile flag memory, walk stack, visited map, neighbor logic and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdfs_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  gdfs_pkg::in_item_t     in_item,
  input  gdfs_pkg::dp_cmd_t      cmd,
  output gdfs_pkg::dp_status_t   st,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gdfs_pkg::out_item_t    out_item
);
  import gdfs_pkg::*;

  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic [CUR_W-1:0]  cur;
  } stack_entry_t;

  logic [1:0]            flag_mem [TILE_COUNT];
  logic [TILE_COUNT-1:0] flag_vld;
  logic [1:0]            flag_rd;
  logic                  flag_rd_vld;
  logic [1:0]            flags_eff;

  stack_entry_t          stack_mem [TILE_COUNT];
  stack_entry_t          stack_rd;
  logic [ADDR_W-1:0]     stack_rd_addr;
  logic [ADDR_W-1:0]     stack_wr_addr;

  logic [TILE_W-1:0]     start;
  logic [TILE_W-1:0]     goal;
  logic [TILE_W-1:0]     top_tile;
  logic [CUR_W-1:0]      top_cur;
  logic [DEPTH_W-1:0]    depth;
  logic [DEPTH_W-1:0]    k;
  logic [TILE_COUNT-1:0] visited;

  logic [TILE_W-1:0]     nb;
  logic [TILE_W-1:0]     nb_raw;
  logic                  nb_ok;
  logic [TILE_W-1:0]     nb_q;
  logic                  nb_ok_q;
  logic [COL_W-1:0]      col;
  logic [TILE_W:0]       t_ext;
  logic                  load_in_range;

  // Neighbor of the top tile in the direction the cursor points at.
  always_comb begin
    col    = COL_TAB[top_tile];
    t_ext  = {1'b0, top_tile};
    nb_raw = '0;
    nb_ok  = 1'b0;
    case (dir_t'(top_cur[1:0]))
      DIR_LEFT: begin
        nb_ok  = (col != '0);
        nb_raw = top_tile - TILE_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok  = (col != COL_W'(GRID_WIDTH - 1))
                 && ((t_ext + (TILE_W+1)'(1)) < (TILE_W+1)'(TILE_COUNT));
        nb_raw = top_tile + TILE_W'(1);
      end
      DIR_UP: begin
        nb_ok  = (t_ext >= (TILE_W+1)'(GRID_WIDTH));
        nb_raw = top_tile - TILE_W'(GRID_WIDTH);
      end
      DIR_DOWN: begin
        nb_ok  = ((t_ext + (TILE_W+1)'(GRID_WIDTH)) < (TILE_W+1)'(TILE_COUNT));
        nb_raw = top_tile + TILE_W'(GRID_WIDTH);
      end
      default: begin
        nb_ok  = 1'b0;
        nb_raw = '0;
      end
    endcase
    nb = nb_ok ? nb_raw : '0;
  end

  assign load_in_range = (in_item.tile_index < TILE_W'(TILE_COUNT));
  assign flags_eff     = flag_rd_vld ? flag_rd : 2'b00;

  assign stack_rd_addr = cmd.pop ? ADDR_W'(depth - DEPTH_W'(2)) : ADDR_W'(k);
  assign stack_wr_addr = ADDR_W'(depth - DEPTH_W'(1));

  always_comb begin
    st.is_search     = (in_item.op == OP_SEARCH);
    st.start_eq_goal = (in_item.start_tile == in_item.goal_tile);
    st.start_oob     = (in_item.start_tile >= TILE_W'(TILE_COUNT));
    st.cur_done      = (top_cur == NB_DONE);
    st.nb_is_goal    = (nb_q == goal);
    st.enter         = nb_ok_q && !visited[nb_q] && flags_eff[FLAG_FLAT]
                       && ((nb_q == goal) || flags_eff[FLAG_UNOCC])
                       && (depth < DEPTH_W'(TILE_COUNT));
    st.depth_is_one  = (depth == DEPTH_W'(1));
    st.k_is_last     = (k == depth - DEPTH_W'(1));
    st.out_free      = !out_valid || out_ready;
  end

  // Flag memory: one write port for loads, one registered read for the walk.
  always_ff @(posedge clk) begin
    if (cmd.flag_wr && load_in_range) begin
      flag_mem[in_item.tile_index[ADDR_W-1:0]] <= {in_item.tile_flat,
                                                   in_item.tile_unoccupied};
    end
    if (cmd.try_nb) begin
      flag_rd     <= flag_mem[nb[ADDR_W-1:0]];
      flag_rd_vld <= flag_vld[nb[ADDR_W-1:0]];
    end
  end

  // Tiles never loaded read as all-zero flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_vld <= '0;
    end else if (cmd.flag_wr && load_in_range) begin
      flag_vld[in_item.tile_index[ADDR_W-1:0]] <= 1'b1;
    end
  end

  // Walk stack below the top entry; the top lives in top_tile/top_cur.
  always_ff @(posedge clk) begin
    if (cmd.push || cmd.store_top) begin
      stack_mem[stack_wr_addr] <= '{tile: top_tile, cur: top_cur};
    end
    stack_rd <= stack_mem[stack_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      visited   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.init) begin
        depth   <= DEPTH_W'(1);
        visited <= TILE_COUNT'(1) << start;
      end else if (cmd.push) begin
        depth <= depth + DEPTH_W'(1);
        if (!st.nb_is_goal) begin
          visited[nb_q] <= 1'b1;
        end
      end else if (cmd.pop) begin
        depth <= depth - DEPTH_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      start <= in_item.start_tile;
      goal  <= in_item.goal_tile;
    end
    if (cmd.init) begin
      top_tile <= start;
      top_cur  <= '0;
    end else if (cmd.try_nb) begin
      top_cur <= top_cur + CUR_W'(1);
    end else if (cmd.push) begin
      top_tile <= nb_q;
      top_cur  <= '0;
    end else if (cmd.pop_load) begin
      top_tile <= stack_rd.tile;
      top_cur  <= stack_rd.cur;
    end
    if (cmd.try_nb) begin
      nb_q    <= nb;
      nb_ok_q <= nb_ok;
    end
    if (cmd.store_top) begin
      k <= '0;
    end else if (cmd.emit_next) begin
      k <= k + DEPTH_W'(1);
    end
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_SAME: out_item <= '{path_tile: start, found: 1'b1, last: 1'b1};
        OUT_NONE: out_item <= '{path_tile: '0, found: 1'b0, last: 1'b1};
        OUT_PATH: out_item <= '{path_tile: stack_rd.tile, found: 1'b1,
                                last: st.k_is_last};
        default:  out_item <= '{path_tile: '0, found: 1'b0, last: 1'b1};
      endcase
    end
  end

  `ASSERT_ALWAYS(a_depth_bound, depth <= DEPTH_W'(TILE_COUNT), "walk stack deeper than tile count")
  `ASSERT_NEXT(a_push_marks, cmd.push && !st.nb_is_goal, visited[top_tile], "pushed tile not marked visited")
  `ASSERT_IMPLIES(a_pop_nonempty, cmd.pop, depth != '0, "pop from an empty walk stack")

endmodule

@@ hw/rtl/gdfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// gdfs_ctrl
// Sequencer for loads, the depth-first walk and the emission of the path.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gdfs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gdfs_pkg::dp_status_t st,
  output gdfs_pkg::dp_cmd_t    cmd
);
  import gdfs_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_INIT    = 11'b00000000010,
    S_TRY     = 11'b00000000100,
    S_DECIDE  = 11'b00000001000,
    S_POP     = 11'b00000010000,
    S_POPLD   = 11'b00000100000,
    S_FOUND   = 11'b00001000000,
    S_EMIT_RD = 11'b00010000000,
    S_EMIT_LD = 11'b00100000000,
    S_SAME    = 11'b01000000000,
    S_NONE    = 11'b10000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (st.is_search) begin
            cmd.capture = 1'b1;
            if (st.start_eq_goal) begin
              state_next = S_SAME;
            end else if (st.start_oob) begin
              state_next = S_NONE;
            end else begin
              state_next = S_INIT;
            end
          end else begin
            cmd.flag_wr = 1'b1;
          end
        end
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_TRY;
      end
      S_TRY: begin
        if (st.cur_done) begin
          state_next = S_POP;
        end else begin
          cmd.try_nb = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (st.enter) begin
          cmd.push   = 1'b1;
          state_next = st.nb_is_goal ? S_FOUND : S_TRY;
        end else begin
          state_next = S_TRY;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = st.depth_is_one ? S_NONE : S_POPLD;
      end
      S_POPLD: begin
        cmd.pop_load = 1'b1;
        state_next   = S_TRY;
      end
      S_FOUND: begin
        cmd.store_top = 1'b1;
        state_next    = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (st.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_sel   = OUT_PATH;
          cmd.emit_next = 1'b1;
          state_next    = st.k_is_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_SAME: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_SAME;
          state_next   = S_IDLE;
        end
      end
      S_NONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_NONE;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ASSERT_IMPLIES(a_load_when_free, cmd.out_load, st.out_free, "result register overwritten")
  `ASSERT_IMPLIES(a_try_in_range, cmd.try_nb, !st.cur_done, "neighbor tried past the last direction")
  `ASSERT_ALWAYS(a_state_onehot, $onehot(state), "sequencer state is not one-hot")

endmodule

@@ hw/rtl/grid_dfs_path_finder_top.sv @@
// ----------------------------------------------------------------------------
// grid_dfs_path_finder_top
// Depth-first path search on a 6x6 tile grid. Input beats on in_ch either load
// the two flags of one tile (op 0, no result) or start a search (op 1). A
// search walks with an explicit stack, trying left, right, up, down, and sends
// the path from start to goal on out_ch, one beat per tile, with last set on
// the final beat; with no path it sends one beat with found clear. Each
// neighbor tried takes a registered read of the tile flag memory; each pop
// takes a check that the cursor is exhausted, a registered read of the stack
// memory and a reload of the top. One item is worked on at a time; in_ch.ready
// is high while the block is idle, also while the last result beat still
// waits. Reset clears the tile flags (all tiles read as blocked), the stack
// depth and the result valid bit. A stall on out_ch holds the result register
// and the sequencer until the beat is taken.
// ----------------------------------------------------------------------------
module grid_dfs_path_finder_top (
  input  logic         clk,
  input  logic         rst,
  gdfs_in_if.sink      in_ch,
  gdfs_out_if.source   out_ch
);
  import gdfs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // The sequencer decides what happens each cycle; the datapath owns storage.
  gdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  gdfs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_ch.data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.data)
  );

endmodule
